/* rtl/b64_pkg.sv */
// Shared types, constants and the character map for the Base64 stream decoder.
package b64_pkg;

    // ASCII codes of the alphabet boundaries
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [7:0] CHAR_D0    = 8'h30;
    localparam logic [7:0] CHAR_D9    = 8'h39;

    // Sextet offsets of the alphabet sections
    localparam logic [5:0] SEXT_PLUS   = 6'd62;
    localparam logic [5:0] SEXT_SLASH  = 6'd63;
    localparam logic [5:0] SEXT_LOWER  = 6'd26;
    localparam logic [5:0] SEXT_DIGIT  = 6'd52;

    // Results produced by one completed group or one error
    localparam logic [1:0] NRES_ONE   = 2'd1;
    localparam logic [1:0] NRES_TWO   = 2'd2;
    localparam logic [1:0] NRES_THREE = 2'd3;

    // Character class after mapping
    typedef struct packed {
        logic       bad;
        logic       pad;
        logic [5:0] sextet;
    } char_class_t;

    // One unit of work handed from the front to the back
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nres;
        logic       err;
        logic       mend;
    } job_t;

    // Map an ASCII code to a sextet, a pad mark or a bad mark
    function automatic char_class_t map_char(input logic [7:0] c);
        char_class_t r;
        r = '{bad: 1'b0, pad: 1'b0, sextet: 6'd0};
        if (c == CHAR_PLUS) begin
            r.sextet = SEXT_PLUS;
        end
        else if (c == CHAR_SLASH) begin
            r.sextet = SEXT_SLASH;
        end
        else if (c >= CHAR_UA && c <= CHAR_UZ) begin
            r.sextet = 6'(c - CHAR_UA);
        end
        else if (c >= CHAR_LA && c <= CHAR_LZ) begin
            r.sextet = 6'(c - CHAR_LA) + SEXT_LOWER;
        end
        else if (c >= CHAR_D0 && c <= CHAR_D9) begin
            r.sextet = 6'(c - CHAR_D0) + SEXT_DIGIT;
        end
        else if (c == CHAR_PAD) begin
            r.pad = 1'b1;
        end
        else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/b64_if.sv */
// Valid/ready channel interfaces for the character input and the byte output.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       last_char;

    modport source (output valid, output in_char, output last_char, input ready);
    modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_error;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output out_byte, output is_error, output run_last,
                    output message_end, input ready);
    modport sink   (input valid, input out_byte, input is_error, input run_last,
                    input message_end, output ready);
endinterface

/* rtl/b64_front.sv */
// Front end: accepts characters, tracks the group and queues byte or error jobs.
module b64_front
    import b64_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    b64_in_if.sink       in_ch,
    input  logic         q_full,
    output logic         q_push,
    output job_t         q_job
);

    logic [17:0] store_reg, store_next;
    logic [1:0]  pos_reg, pos_next;
    logic        pad_seen_reg, pad_seen_next;
    logic        discard_reg, discard_next;

    char_class_t cls;
    logic        fire;
    logic        last;
    logic        err;
    logic        pos_full;
    logic [5:0]  s0, s1, s2;

    assign in_ch.ready = !q_full;
    assign fire        = in_ch.valid && !q_full;
    assign last        = in_ch.last_char;
    assign cls         = map_char(in_ch.in_char);
    assign pos_full    = (pos_reg == 2'd3);

    assign s0 = store_reg[17:12];
    assign s1 = store_reg[11:6];
    assign s2 = store_reg[5:0];

    // Any malformed-input condition
    assign err = cls.bad
               | (!pos_full && last)
               | (!pos_full && cls.pad && !pos_reg[1])
               | (pos_full && !cls.pad && pad_seen_reg)
               | (pos_full && cls.pad && !last);

    // Group state update and job build
    always_comb
    begin
        store_next    = store_reg;
        pos_next      = pos_reg;
        pad_seen_next = pad_seen_reg;
        discard_next  = discard_reg;
        q_push        = 1'b0;
        q_job         = '{b0: 8'd0, b1: 8'd0, b2: 8'd0, nres: NRES_ONE, err: 1'b0,
                          mend: 1'b1};
        if (fire)
        begin
            if (discard_reg)
            begin
                if (last)
                begin
                    discard_next  = 1'b0;
                    store_next    = '0;
                    pos_next      = '0;
                    pad_seen_next = 1'b0;
                end
            end
            else if (err)
            begin
                store_next    = '0;
                pos_next      = '0;
                pad_seen_next = 1'b0;
                discard_next  = !last;
                q_push        = 1'b1;
                q_job.err     = 1'b1;
            end
            else if (!pos_full)
            begin
                if (cls.pad)
                begin
                    pad_seen_next = 1'b1;
                    store_next    = {store_reg[11:0], 6'd0};
                end
                else
                begin
                    store_next = {store_reg[11:0], cls.sextet};
                end
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                // fourth character closes the group
                store_next    = '0;
                pos_next      = '0;
                pad_seen_next = 1'b0;
                q_push        = 1'b1;
                q_job.b0      = {s0, s1[5:4]};
                q_job.b1      = {s1[3:0], s2[5:2]};
                q_job.b2      = {s2[1:0], cls.sextet};
                if (cls.pad)
                begin
                    q_job.nres = pad_seen_reg ? NRES_ONE : NRES_TWO;
                    q_job.mend = 1'b1;
                end
                else
                begin
                    q_job.nres = NRES_THREE;
                    q_job.mend = last;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg    <= '0;
            pos_reg      <= '0;
            pad_seen_reg <= 1'b0;
            discard_reg  <= 1'b0;
        end
        else
        begin
            store_reg    <= store_next;
            pos_reg      <= pos_next;
            pad_seen_reg <= pad_seen_next;
            discard_reg  <= discard_next;
        end
    end

endmodule

/* rtl/b64_queue.sv */
// Small job queue between the front and the back.
module b64_queue
    import b64_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/b64_back.sv */
// Back end: unpacks queued jobs into one result transaction per cycle while the output accepts them.
module b64_back
    import b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head,
    input  logic      q_empty,
    output logic      q_pop,
    b64_out_if.source out_ch
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       err_reg;
    logic       rlast_reg;
    logic       mend_reg;

    logic       load;
    logic       final_res;
    logic [7:0] sel_byte;

    assign load      = !q_empty && (!valid_reg || out_ch.ready);
    assign final_res = (idx_reg == head.nres - 2'd1);
    assign q_pop     = load && final_res;

    // Byte select by result index
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.b0;
            2'd1:    sel_byte = head.b1;
            2'd2:    sel_byte = head.b2;
            default: sel_byte = 8'd0;
        endcase
    end

    // Index and output valid update
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = final_res ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= head.err ? 8'd0 : sel_byte;
            err_reg   <= head.err;
            rlast_reg <= final_res;
            mend_reg  <= final_res && head.mend;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_byte    = byte_reg;
    assign out_ch.is_error    = err_reg;
    assign out_ch.run_last    = rlast_reg;
    assign out_ch.message_end = mend_reg;

endmodule

/* rtl/base64_stream_decoder.sv */
// Top level of the streaming Base64 decoder.
//
//  channel     dir   handshake     payload
//  in_stream   in    valid/ready   in_char[7:0], last_char
//  out_stream  out   valid/ready   out_byte[7:0], is_error, run_last, message_end
//
// One character is taken per cycle while the job queue has room.
// Results pass the job queue, then the output register; one byte a cycle while ready.
// Queue of QUEUE_DEPTH jobs decouples input stalls from output stalls.
// Reset is asynchronous and clears group state, queue pointers and output valid.
module base64_stream_decoder
    import b64_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    b64_in_if.sink    in_stream,
    b64_out_if.source out_stream
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    job_t push_job;
    job_t head_job;

    b64_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_stream),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (push_job)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    b64_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head_job),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .out_ch  (out_stream)
    );

endmodule

/* rtl/b64_checker.sv */
// Port-level assertions for the Base64 decoder and their bind.
module b64_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       is_error,
    input logic       run_last,
    input logic       message_end
);

    // Error transaction is a lone, final, zero result
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_error |-> out_byte == 8'd0 && run_last && message_end)
        else $error("error result malformed");

    // Message end falls only on the last result of a character
    a_mend_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> run_last)
        else $error("message_end without run_last");

    // Stalled output keeps valid
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("valid dropped under stall");

    // Stalled output keeps payload
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(is_error)
            && $stable(run_last) && $stable(message_end))
        else $error("payload changed under stall");

endmodule

bind base64_stream_decoder b64_checker u_b64_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_stream.valid),
    .out_ready   (out_stream.ready),
    .out_byte    (out_stream.out_byte),
    .is_error    (out_stream.is_error),
    .run_last    (out_stream.run_last),
    .message_end (out_stream.message_end)
);

/* sim/tb_top.sv */
// Self-checking testbench for the streaming Base64 decoder, with its own decode predictor.
`timescale 1ns / 100ps

import b64_pkg::*;

// Character class seen by the predictor
typedef enum logic [1:0] {SYM_DATA, SYM_PAD, SYM_BAD} sym_kind_t;

// One decoded byte or error result as seen on the output channel
typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       rlast;
    logic       mend;
} dec_result_t;

// Tracks decoder state from accepted characters and checks the bytes that come out
class decode_checker;
    dec_result_t pending_bytes[$];
    logic [17:0] group_bits;
    logic [1:0]  group_fill;
    logic        pad_in_group;
    logic        dropping;
    int          taken;
    int          skipped;
    int          bytes_seen;
    int          errors_seen;
    int          messages_seen;
    int          fails;

    function new();
        group_bits   = '0;
        group_fill   = '0;
        pad_in_group = 1'b0;
        dropping     = 1'b0;
    endfunction

    function void clear_group();
        group_bits   = '0;
        group_fill   = '0;
        pad_in_group = 1'b0;
    endfunction

    function void push(logic [7:0] d, logic e, logic rl, logic me);
        dec_result_t r;
        r.data  = d;
        r.err   = e;
        r.rlast = rl;
        r.mend  = me;
        pending_bytes.push_back(r);
    endfunction

    function void flag_error(logic l);
        clear_group();
        dropping = !l;
        push(8'h00, 1'b1, 1'b1, 1'b1);
    endfunction

    // Alphabet lookup: sextet value or pad/bad class
    function void classify(input logic [7:0] c, output sym_kind_t k, output logic [5:0] sx);
        k  = SYM_DATA;
        sx = '0;
        if (c >= CHAR_UA && c <= CHAR_UZ)
            sx = 6'(c - CHAR_UA);
        else if (c >= CHAR_LA && c <= CHAR_LZ)
            sx = 6'(c - CHAR_LA + 8'd26);
        else if (c >= CHAR_D0 && c <= CHAR_D9)
            sx = 6'(c - CHAR_D0 + 8'd52);
        else if (c == CHAR_PLUS)
            sx = SEXT_PLUS;
        else if (c == CHAR_SLASH)
            sx = SEXT_SLASH;
        else if (c == CHAR_PAD)
            k = SYM_PAD;
        else
            k = SYM_BAD;
    endfunction

    // Called once per accepted character transaction
    function void note_char(logic [7:0] c, logic l);
        sym_kind_t  k;
        logic [5:0] sx;
        logic [5:0] s0, s1, s2;
        logic [7:0] b0, b1, b2;
        logic       two_pads;

        // resync: swallow everything up to the last-marked character
        if (dropping) begin
            skipped++;
            if (l) begin
                dropping = 1'b0;
                clear_group();
            end
            return;
        end
        taken++;
        classify(c, k, sx);

        if (k == SYM_BAD) begin
            flag_error(l);
            return;
        end

        // first three positions only collect
        if (group_fill != 2'd3) begin
            if (l || (k == SYM_PAD && group_fill < 2'd2)) begin
                flag_error(l);
                return;
            end
            if (k == SYM_PAD) begin
                pad_in_group = 1'b1;
                group_bits   = {group_bits[11:0], 6'd0};
            end
            else begin
                group_bits = {group_bits[11:0], sx};
            end
            group_fill++;
            return;
        end

        // fourth position closes the group
        if ((k == SYM_DATA && pad_in_group) || (k == SYM_PAD && !l)) begin
            flag_error(l);
            return;
        end
        s0 = group_bits[17:12];
        s1 = group_bits[11:6];
        s2 = group_bits[5:0];
        b0 = {s0, s1[5:4]};
        b1 = {s1[3:0], s2[5:2]};
        b2 = {s2[1:0], (k == SYM_PAD) ? 6'd0 : sx};
        two_pads = pad_in_group;
        clear_group();
        if (k == SYM_PAD) begin
            if (two_pads) begin
                push(b0, 1'b0, 1'b1, 1'b1);
            end
            else begin
                push(b0, 1'b0, 1'b0, 1'b0);
                push(b1, 1'b0, 1'b1, 1'b1);
            end
        end
        else begin
            push(b0, 1'b0, 1'b0, 1'b0);
            push(b1, 1'b0, 1'b0, 1'b0);
            push(b2, 1'b0, 1'b1, l);
        end
    endfunction

    function void compare(string field, logic [7:0] e, logic [7:0] a);
        if (e !== a) begin
            fails++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, e, a);
        end
    endfunction

    // Called once per accepted output transaction
    function void check_byte(dec_result_t got);
        dec_result_t want;
        if (pending_bytes.size() == 0) begin
            fails++;
            $display("%0t: unexpected output, expected none, actual %h err %b rl %b me %b",
                     $time, got.data, got.err, got.rlast, got.mend);
            return;
        end
        want = pending_bytes.pop_front();
        compare("out_byte", want.data, got.data);
        compare("is_error", 8'(want.err), 8'(got.err));
        compare("run_last", 8'(want.rlast), 8'(got.rlast));
        compare("message_end", 8'(want.mend), 8'(got.mend));
        if (got.err)
            errors_seen++;
        else
            bytes_seen++;
        if (got.mend)
            messages_seen++;
    endfunction

    function int pending_count();
        return pending_bytes.size();
    endfunction
endclass

module tb_top;

    logic clk = 1'b0;
    logic rst_n;

    b64_in_if  in_if();
    b64_out_if out_if();

    base64_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if)
    );

    decode_checker sb;
    dec_result_t   out_seen;
    logic          in_idle;
    logic          out_idle;
    logic          stall_req;
    int            stall_left;

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Output side: check each transaction, then pick next ready
    always @(posedge clk) begin
        if (out_if.valid && out_if.ready) begin
            out_seen.data  = out_if.out_byte;
            out_seen.err   = out_if.is_error;
            out_seen.rlast = out_if.run_last;
            out_seen.mend  = out_if.message_end;
            sb.check_byte(out_seen);
        end
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end
        else if (stall_req) begin
            // long hold-off so the job queue backs up into the input
            stall_req  = 1'b0;
            stall_left = 80;
            out_if.ready <= 1'b0;
        end
        else begin
            out_if.ready <= !(out_idle && $urandom_range(0, 99) < 16);
        end
    end

    // One character transaction, with an occasional gap in front
    task automatic send_char(input logic [7:0] c, input logic l);
        if (in_idle && $urandom_range(0, 99) < 16) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.in_char   <= c;
        in_if.last_char <= l;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        sb.note_char(c, l);
    endtask

    task automatic send_text(input string s, input logic mark_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], mark_last && (i == s.len() - 1));
    endtask

    // Stop sending until every predicted result has come out
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26)
            return CHAR_UA + 8'(v);
        else if (v < 6'd52)
            return CHAR_LA + 8'(v - 6'd26);
        else if (v < 6'd62)
            return CHAR_D0 + 8'(v - 6'd52);
        else if (v == SEXT_PLUS)
            return CHAR_PLUS;
        return CHAR_SLASH;
    endfunction

    // Mostly well-formed messages with random content, some broken on purpose
    task automatic send_random_message();
        logic [7:0] msg[$];
        int groups;
        int tail;
        int kind;
        int at;
        groups = $urandom_range(0, 3);
        repeat (groups * 4) msg.push_back(sextet_char(6'($urandom)));
        tail = $urandom_range(0, 2);
        repeat (4 - tail) msg.push_back(sextet_char(6'($urandom)));
        repeat (tail) msg.push_back(CHAR_PAD);

        kind = $urandom_range(0, 99);
        at   = $urandom_range(0, msg.size() - 1);
        if (kind >= 72 && kind < 80)
            msg[at] = 8'($urandom_range(0, 255));
        else if (kind >= 80 && kind < 86)
            msg[at] = CHAR_PAD;
        else if (kind >= 86 && kind < 92)
            msg.delete(at);
        else if (kind >= 92)
            msg.push_back(sextet_char(6'($urandom)));

        foreach (msg[i])
            send_char(msg[i], i == msg.size() - 1);
    endtask

    // Random bytes with random last marks
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    // Stimulus
    initial begin
        int  done;
        logic stall_done;
        logic pause_done;

        in_if.valid     = 1'b0;
        in_if.in_char   = 8'h00;
        in_if.last_char = 1'b0;
        out_if.ready    = 1'b0;
        rst_n           = 1'b0;
        in_idle         = 1'b1;
        out_idle        = 1'b1;
        stall_req       = 1'b0;
        stall_left      = 0;
        stall_done      = 1'b0;
        pause_done      = 1'b0;
        sb = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // alphabet edges across two full groups, first one not message end
        send_text("+/09azAZ", 1'b1);
        // two pads and one pad, both with nonzero bits under the padding
        send_text("TR==", 1'b1);
        send_text("TWF=", 1'b1);
        // invalid character on a last-marked transaction restarts at once
        send_char(8'hFF, 1'b1);
        // message too short
        send_text("Z", 1'b1);
        // invalid character mid-message, rest dropped through the last mark
        send_char(8'h00, 1'b0);
        send_text("Q=", 1'b1);
        // data after padding
        send_text("AB=A", 1'b1);
        // pad in first position, then resync
        send_text("=", 1'b0);
        send_text("x", 1'b1);
        wait_drained();

        // count every character transaction, dropped ones included
        done = sb.taken + sb.skipped;
        while (done < 470) begin
            if (done >= 100 && !stall_done) begin
                stall_req  = 1'b1;
                stall_done = 1'b1;
            end
            if (done >= 220 && !pause_done) begin
                wait_drained();
                pause_done = 1'b1;
            end
            // quiet stretch: no gaps on either side
            in_idle  = !(done >= 260 && done < 360);
            out_idle = in_idle;
            if ($urandom_range(0, 99) < 88)
                send_random_message();
            else
                send_noise();
            done = sb.taken + sb.skipped;
        end
        in_if.valid <= 1'b0;

        while (sb.pending_count() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.pending_count() != 0)
            sb.fails++;

        $display("Run covered %0d decoded characters and %0d dropped during resync,",
                 sb.taken, sb.skipped);
        $display("giving %0d bytes, %0d error results and %0d message ends.",
                 sb.bytes_seen, sb.errors_seen, sb.messages_seen);
        if (sb.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
